// File: rtl/core/lfu_page_replacement_top_assert.svh
// Assertion macros for the LFU page replacement block.
// Included by the top level; needs nothing else.
`ifndef LFU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LFU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// Implication in the same cycle, checked out of reset.
`define LFU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lfu: same-cycle check failed");

// Implication in the next cycle, checked out of reset.
`define LFU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lfu: next-cycle check failed");

`endif

// File: rtl/core/lfu_pkg.sv
// Shared constants and types for the LFU page replacement block.
// No dependencies; used by lfu_cell and lfu_page_replacement_top.
`default_nettype none

package lfu_pkg;

  localparam int FRAMES_DEF     = 8;
  localparam int PAGE_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam int PAGE_PORT_W = 16;
  localparam int SLOT_PORT_W = 3;
  localparam int TOTAL_W     = 32;
  localparam int TIME_W      = 32;
  localparam int CFG_W       = 4;

  localparam logic [CFG_W-1:0] CFG_FRAMES_RESET = 4'd8;

  // Search status carried along the row of cells with one reference.
  typedef struct packed {
    logic active;
    logic hit;
    logic free_found;
    logic best_set;
    logic last;
  } carry_flags_t;

  // Update broadcast to all cells once the search is complete.
  typedef struct packed {
    logic valid;
    logic is_hit;
    logic clear;
  } commit_t;

endpackage

`default_nettype wire

// File: rtl/core/lfu_page_replacement_top.sv
// Top level of the LFU page replacement block with FIFO tie-break.
// Depends on lfu_pkg, lfu_cell and lfu_page_replacement_top_assert.svh.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------------
//   input    | start / busy          | in_page, in_last_reference
//   result   | out_valid (one cycle) | out_hit, out_slot, out_evicted_valid,
//            |                       | out_evicted_page, out_fault_total
//   config   | cfg_we                | cfg_wdata (frames_in_use)
//
// A reference travels down the row of FRAMES cells, one cell per cycle, and is
// committed from the output register of the last cell; the block holds busy
// meanwhile and takes no new reference until the result is out.
// The result is shown for one cycle as busy falls; the next start is taken then.
// Reset is synchronous and active low and empties all slots at once.
// The receiver cannot stall; results are never held back.
`default_nettype none

module lfu_page_replacement_top #(
  parameter int FRAMES     = lfu_pkg::FRAMES_DEF,
  parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire [lfu_pkg::PAGE_PORT_W-1:0]   in_page,
  input  wire                              in_last_reference,
  output logic                             out_valid,
  output logic                             out_hit,
  output logic [lfu_pkg::SLOT_PORT_W-1:0]  out_slot,
  output logic                             out_evicted_valid,
  output logic [lfu_pkg::PAGE_PORT_W-1:0]  out_evicted_page,
  output logic [lfu_pkg::TOTAL_W-1:0]      out_fault_total,
  input  wire                              cfg_we,
  input  wire [lfu_pkg::CFG_W-1:0]         cfg_wdata
);
  import lfu_pkg::*;

  `include "lfu_page_replacement_top_assert.svh"

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  // Configuration and counters
  logic [CFG_W-1:0]   cfg_frames_r;
  logic [TIME_W-1:0]  ref_index_r, ref_index_nxt;
  logic [TOTAL_W-1:0] fault_r, fault_nxt;
  logic               busy_r, busy_nxt;
  logic [IDX_W:0]     eff_n;

  // Result registers
  logic                   out_valid_r, out_hit_r, out_ev_valid_r;
  logic [SLOT_PORT_W-1:0] out_slot_r;
  logic [PAGE_PORT_W-1:0] out_ev_page_r;
  logic [TOTAL_W-1:0]     out_fault_r;

  // Carry chain between cells
  carry_flags_t          ch_flg   [0:FRAMES];
  logic [PAGE_BITS-1:0]  ch_page  [0:FRAMES];
  logic [IDX_W-1:0]      ch_hslot [0:FRAMES];
  logic [IDX_W-1:0]      ch_fslot [0:FRAMES];
  logic [IDX_W-1:0]      ch_bslot [0:FRAMES];
  logic [COUNT_BITS-1:0] ch_bcnt  [0:FRAMES];
  logic [TIME_W-1:0]     ch_btime [0:FRAMES];
  logic [PAGE_BITS-1:0]  ch_bpage [0:FRAMES];

  commit_t               cmt;
  logic [IDX_W-1:0]      cmt_slot;

  logic                         accept, done, miss, ev_valid;
  logic [PAGE_BITS+PAGE_PORT_W-1:0] in_page_ext, ev_page_ext;
  logic [IDX_W+SLOT_PORT_W-1:0]     slot_ext;

  assign accept = start && !busy_r;
  assign done   = ch_flg[FRAMES].active;

  // Out-of-range slot counts: zero acts as one, above FRAMES acts as FRAMES.
  always_comb begin
    if (cfg_frames_r == '0) begin
      eff_n = (IDX_W + 1)'(1);
    end else if (int'(cfg_frames_r) > FRAMES) begin
      eff_n = (IDX_W + 1)'(FRAMES);
    end else begin
      eff_n = (IDX_W + 1)'(cfg_frames_r);
    end
  end

  always_comb begin
    in_page_ext = {{PAGE_BITS{1'b0}}, in_page};
    ch_flg[0]            = '0;
    ch_flg[0].active     = accept;
    ch_flg[0].last       = in_last_reference;
    ch_page[0]           = in_page_ext[PAGE_BITS-1:0];
    ch_hslot[0]          = '0;
    ch_fslot[0]          = '0;
    ch_bslot[0]          = '0;
    ch_bcnt[0]           = '0;
    ch_btime[0]          = '0;
    ch_bpage[0]          = '0;
  end

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lfu_cell #(
      .FRAMES     (FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .COUNT_BITS (COUNT_BITS),
      .CELL_IDX   (g)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .eff_n       (eff_n),
      .flg_i       (ch_flg[g]),
      .page_i      (ch_page[g]),
      .hit_slot_i  (ch_hslot[g]),
      .free_slot_i (ch_fslot[g]),
      .best_slot_i (ch_bslot[g]),
      .best_cnt_i  (ch_bcnt[g]),
      .best_time_i (ch_btime[g]),
      .best_page_i (ch_bpage[g]),
      .flg_o       (ch_flg[g+1]),
      .page_o      (ch_page[g+1]),
      .hit_slot_o  (ch_hslot[g+1]),
      .free_slot_o (ch_fslot[g+1]),
      .best_slot_o (ch_bslot[g+1]),
      .best_cnt_o  (ch_bcnt[g+1]),
      .best_time_o (ch_btime[g+1]),
      .best_page_o (ch_bpage[g+1]),
      .cmt_i       (cmt),
      .cmt_slot_i  (cmt_slot),
      .cmt_page_i  (ch_page[FRAMES]),
      .cmt_time_i  (ref_index_r)
    );
  end

  always_comb begin
    miss     = !ch_flg[FRAMES].hit;
    ev_valid = miss && !ch_flg[FRAMES].free_found;
    if (!miss) begin
      cmt_slot = ch_hslot[FRAMES];
    end else if (ch_flg[FRAMES].free_found) begin
      cmt_slot = ch_fslot[FRAMES];
    end else begin
      cmt_slot = ch_bslot[FRAMES];
    end
    cmt.valid  = done;
    cmt.is_hit = !miss;
    cmt.clear  = ch_flg[FRAMES].last;

    slot_ext    = {{SLOT_PORT_W{1'b0}}, cmt_slot};
    ev_page_ext = {{PAGE_PORT_W{1'b0}}, ch_bpage[FRAMES]};

    fault_nxt     = fault_r;
    ref_index_nxt = ref_index_r;
    busy_nxt      = busy_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (done) begin
      busy_nxt = 1'b0;
      if (miss && (fault_r != '1)) begin
        fault_nxt = fault_r + 1'b1;
      end
      if (ref_index_r != '1) begin
        ref_index_nxt = ref_index_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_frames_r <= CFG_FRAMES_RESET;
      ref_index_r  <= '0;
      fault_r      <= '0;
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_frames_r <= cfg_wdata;
      end
      busy_r      <= busy_nxt;
      out_valid_r <= done;
      if (done && ch_flg[FRAMES].last) begin
        ref_index_r <= '0;
        fault_r     <= '0;
      end else begin
        ref_index_r <= ref_index_nxt;
        fault_r     <= fault_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_hit_r      <= !miss;
      out_slot_r     <= slot_ext[SLOT_PORT_W-1:0];
      out_ev_valid_r <= ev_valid;
      out_ev_page_r  <= ev_valid ? ev_page_ext[PAGE_PORT_W-1:0] : '0;
      out_fault_r    <= fault_nxt;
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_hit           = out_hit_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_page  = out_ev_page_r;
  assign out_fault_total   = out_fault_r;

  `LFU_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy_r)
  `LFU_ASSERT_SAME(a_done_in_flight, clk, rst_n, done, busy_r)
  `LFU_ASSERT_SAME(a_result_idle, clk, rst_n, out_valid_r, !busy_r)
  `LFU_ASSERT_SAME(a_hit_no_evict, clk, rst_n, out_valid_r && out_hit_r, !out_ev_valid_r)

endmodule

`default_nettype wire

// File: rtl/core/lfu_cell.sv
// One frame slot of the LFU row: slot state plus one stage of the search carry.
// Depends on lfu_pkg.
`default_nettype none

module lfu_cell #(
  parameter int FRAMES     = lfu_pkg::FRAMES_DEF,
  parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
  parameter int CELL_IDX   = 0,
  localparam int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire [IDX_W:0]                eff_n,
  input  lfu_pkg::carry_flags_t        flg_i,
  input  wire [PAGE_BITS-1:0]          page_i,
  input  wire [IDX_W-1:0]              hit_slot_i,
  input  wire [IDX_W-1:0]              free_slot_i,
  input  wire [IDX_W-1:0]              best_slot_i,
  input  wire [COUNT_BITS-1:0]         best_cnt_i,
  input  wire [lfu_pkg::TIME_W-1:0]    best_time_i,
  input  wire [PAGE_BITS-1:0]          best_page_i,
  output lfu_pkg::carry_flags_t        flg_o,
  output logic [PAGE_BITS-1:0]         page_o,
  output logic [IDX_W-1:0]             hit_slot_o,
  output logic [IDX_W-1:0]             free_slot_o,
  output logic [IDX_W-1:0]             best_slot_o,
  output logic [COUNT_BITS-1:0]        best_cnt_o,
  output logic [lfu_pkg::TIME_W-1:0]   best_time_o,
  output logic [PAGE_BITS-1:0]         best_page_o,
  input  lfu_pkg::commit_t             cmt_i,
  input  wire [IDX_W-1:0]              cmt_slot_i,
  input  wire [PAGE_BITS-1:0]          cmt_page_i,
  input  wire [lfu_pkg::TIME_W-1:0]    cmt_time_i
);
  import lfu_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);
  localparam logic [IDX_W:0]   MY_POS = (IDX_W + 1)'(CELL_IDX);

  // Slot state
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic                  valid_r, valid_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [TIME_W-1:0]     time_r, time_nxt;

  // Search carry stage
  carry_flags_t          flg_r, flg_nxt;
  logic [PAGE_BITS-1:0]  cpage_r;
  logic [IDX_W-1:0]      hslot_r, hslot_nxt;
  logic [IDX_W-1:0]      fslot_r, fslot_nxt;
  logic [IDX_W-1:0]      bslot_r, bslot_nxt;
  logic [COUNT_BITS-1:0] bcnt_r, bcnt_nxt;
  logic [TIME_W-1:0]     btime_r, btime_nxt;
  logic [PAGE_BITS-1:0]  bpage_r, bpage_nxt;

  logic part, hit_here, free_here, better;
  logic mine;

  always_comb begin
    part      = flg_i.active && (MY_POS < eff_n);
    hit_here  = part && valid_r && (page_r == page_i) && !flg_i.hit;
    free_here = part && !valid_r && !flg_i.free_found;
    better    = part && valid_r &&
                (!flg_i.best_set || (cnt_r < best_cnt_i) ||
                 ((cnt_r == best_cnt_i) && (time_r < best_time_i)));

    flg_nxt            = flg_i;
    flg_nxt.hit        = flg_i.hit | hit_here;
    flg_nxt.free_found = flg_i.free_found | free_here;
    flg_nxt.best_set   = flg_i.best_set | better;
    hslot_nxt = hit_here  ? MY_IDX : hit_slot_i;
    fslot_nxt = free_here ? MY_IDX : free_slot_i;
    bslot_nxt = better    ? MY_IDX : best_slot_i;
    bcnt_nxt  = better    ? cnt_r  : best_cnt_i;
    btime_nxt = better    ? time_r : best_time_i;
    bpage_nxt = better    ? page_r : best_page_i;
  end

  always_comb begin
    mine      = cmt_i.valid && (cmt_slot_i == MY_IDX);
    page_nxt  = page_r;
    valid_nxt = valid_r;
    cnt_nxt   = cnt_r;
    time_nxt  = time_r;
    if (mine) begin
      if (cmt_i.is_hit) begin
        if (cnt_r != '1) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end else begin
        page_nxt  = cmt_page_i;
        valid_nxt = 1'b1;
        cnt_nxt   = COUNT_BITS'(1);
        time_nxt  = cmt_time_i;
      end
    end
    // The end of a reference string empties every slot after its update.
    if (cmt_i.valid && cmt_i.clear) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flg_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      flg_r   <= flg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r  <= page_nxt;
    cnt_r   <= cnt_nxt;
    time_r  <= time_nxt;
    cpage_r <= page_i;
    hslot_r <= hslot_nxt;
    fslot_r <= fslot_nxt;
    bslot_r <= bslot_nxt;
    bcnt_r  <= bcnt_nxt;
    btime_r <= btime_nxt;
    bpage_r <= bpage_nxt;
  end

  assign flg_o       = flg_r;
  assign page_o      = cpage_r;
  assign hit_slot_o  = hslot_r;
  assign free_slot_o = fslot_r;
  assign best_slot_o = bslot_r;
  assign best_cnt_o  = bcnt_r;
  assign best_time_o = btime_r;
  assign best_page_o = bpage_r;

endmodule

`default_nettype wire

// File: bench/tb_lfu_page_replacement_top.sv
`timescale 1ns / 100ps

// Self-checking bench for lfu_page_replacement_top: a queue-fed command driver, a result
// monitor and an in-bench model of LFU replacement with oldest-load tie-break.
// Depends on lfu_pkg and the RTL of the block; reads and writes no files.
module tb_lfu_page_replacement_top;
  import lfu_pkg::*;

  localparam int SLOTS = FRAMES_DEF;
  localparam logic [COUNT_BITS_DEF-1:0] USE_CEILING = '1;
  localparam int REPORT_LIMIT = 100;

  typedef struct packed {
    logic [PAGE_PORT_W-1:0] page;
    logic                   last;
  } page_ref_t;

  typedef struct packed {
    logic                   hit;
    logic [SLOT_PORT_W-1:0] slot;
    logic                   evicted_valid;
    logic [PAGE_PORT_W-1:0] evicted_page;
    logic [TOTAL_W-1:0]     fault_total;
  } frame_outcome_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [PAGE_PORT_W-1:0]  in_page = '0;
  logic                    in_last_reference = 1'b0;
  logic                    out_valid;
  logic                    out_hit;
  logic [SLOT_PORT_W-1:0]  out_slot;
  logic                    out_evicted_valid;
  logic [PAGE_PORT_W-1:0]  out_evicted_page;
  logic [TOTAL_W-1:0]      out_fault_total;
  logic                    cfg_we = 1'b0;
  logic [CFG_W-1:0]        cfg_wdata = CFG_FRAMES_RESET;

  // Replacement model state, mirroring the block's frame table.
  logic [PAGE_PORT_W-1:0]    frame_page   [SLOTS];
  logic                      frame_valid  [SLOTS];
  logic [COUNT_BITS_DEF-1:0] frame_uses   [SLOTS];
  logic [TIME_W-1:0]         frame_loaded [SLOTS];
  logic [TIME_W-1:0]         ref_clock;
  logic [TOTAL_W-1:0]        fault_tally;
  logic [CFG_W-1:0]          frames_cfg;

  page_ref_t      pending_refs[$];
  frame_outcome_t expected_outcomes[$];
  frame_outcome_t head_outcome;
  int             gap_percent = 0;
  int             reported = 0;
  bit             failed = 1'b0;
  bit             take;

  lfu_page_replacement_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page           (in_page),
    .in_last_reference (in_last_reference),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void clear_frames();
    for (int s = 0; s < SLOTS; s++) begin
      frame_page[s]   = '0;
      frame_valid[s]  = 1'b0;
      frame_uses[s]   = '0;
      frame_loaded[s] = '0;
    end
    ref_clock   = '0;
    fault_tally = '0;
  endfunction

  function automatic frame_outcome_t resolve_reference(input logic [PAGE_PORT_W-1:0] pg,
                                                       input logic last_ref);
    frame_outcome_t res;
    int active;
    int where;
    bit found;
    active = (frames_cfg == 0) ? 1 : ((frames_cfg > SLOTS) ? SLOTS : int'(frames_cfg));
    res = '0;
    found = 1'b0;
    where = 0;
    for (int s = 0; s < active; s++) begin
      if (!found && frame_valid[s] && frame_page[s] == pg) begin
        found = 1'b1;
        where = s;
      end
    end
    if (found) begin
      res.hit = 1'b1;
      if (frame_uses[where] != USE_CEILING) frame_uses[where] = frame_uses[where] + 1'b1;
    end else begin
      for (int s = 0; s < active; s++) begin
        if (!found && !frame_valid[s]) begin
          found = 1'b1;
          where = s;
        end
      end
      if (!found) begin
        // Fewest uses loses; equal counts fall to the older load, then the lower slot.
        where = 0;
        for (int s = 1; s < active; s++) begin
          if (frame_uses[s] < frame_uses[where] ||
              (frame_uses[s] == frame_uses[where] && frame_loaded[s] < frame_loaded[where]))
            where = s;
        end
        res.evicted_valid = 1'b1;
        res.evicted_page  = frame_page[where];
      end
      frame_page[where]   = pg;
      frame_valid[where]  = 1'b1;
      frame_uses[where]   = COUNT_BITS_DEF'(1);
      frame_loaded[where] = ref_clock;
      if (fault_tally != '1) fault_tally = fault_tally + 1'b1;
    end
    res.slot        = where[SLOT_PORT_W-1:0];
    res.fault_total = fault_tally;
    if (ref_clock != '1) ref_clock = ref_clock + 1'b1;
    if (last_ref) clear_frames();
    return res;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      failed = 1'b1;
      // Keep the log readable if a fault repeats over a long burst.
      if (reported < REPORT_LIMIT)
        $display("%0t ns: %s expected %0h, got %0h", $time, field, want, got);
      reported++;
    end
  endtask

  task automatic add_ref(input logic [PAGE_PORT_W-1:0] pg, input logic lst);
    pending_refs.push_back(page_ref_t'{pg, lst});
  endtask

  // A reference string drawn from a small working set, so that hits and evictions are common.
  task automatic queue_string(input int length, input bit closed);
    logic [PAGE_PORT_W-1:0] pool [12];
    int pool_size;
    pool_size = $urandom_range(2, 12);
    for (int i = 0; i < pool_size; i++) pool[i] = PAGE_PORT_W'($urandom);
    for (int k = 0; k < length; k++)
      add_ref(pool[$urandom_range(pool_size - 1)], closed && (k == length - 1));
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_refs.size() != 0 || start || busy !== 1'b0 ||
           expected_outcomes.size() != 0);
  endtask

  task automatic write_frames(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    frames_cfg = value;
    @(negedge clk);
  endtask

  // Command driver: a command is held until the block takes it with busy low.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      take = start && (busy === 1'b0);
      if (take) begin
        expected_outcomes.push_back(resolve_reference(in_page, in_last_reference));
        void'(pending_refs.pop_front());
      end
      if (!start || take) begin
        if (pending_refs.size() != 0 && $urandom_range(99) >= gap_percent) begin
          start             <= 1'b1;
          in_page           <= pending_refs[0].page;
          in_last_reference <= pending_refs[0].last;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (expected_outcomes.size() == 0) begin
        failed = 1'b1;
        $display("%0t ns: result transfer expected none, got slot %0d", $time, out_slot);
      end else begin
        head_outcome = expected_outcomes.pop_front();
        check_field("hit", 32'(head_outcome.hit), 32'(out_hit));
        check_field("slot", 32'(head_outcome.slot), 32'(out_slot));
        check_field("evicted_valid", 32'(head_outcome.evicted_valid),
                    32'(out_evicted_valid));
        check_field("evicted_page", 32'(head_outcome.evicted_page), 32'(out_evicted_page));
        check_field("fault_total", head_outcome.fault_total, out_fault_total);
      end
    end
  end

  initial begin : stimulus
    int phase_frames [12];
    int phase_gaps [4];
    int queued;
    int len;
    phase_frames = '{1, 2, 3, 8, 5, 0, 15, 4, 9, 6, 7, 8};
    phase_gaps   = '{0, 74, 0, 27};
    clear_frames();
    frames_cfg = CFG_FRAMES_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Extreme page numbers at the reset slot count, closed by the end-of-string flag.
    add_ref(16'h0000, 1'b0);
    add_ref(16'hFFFF, 1'b0);
    add_ref(16'h0000, 1'b1);
    wait_idle();

    // Three slots: fill, hits, then replacement by least use.
    write_frames(4'd3);
    add_ref(16'h1234, 1'b0);
    add_ref(16'h00FF, 1'b0);
    add_ref(16'hFF00, 1'b0);
    add_ref(16'h1234, 1'b0);
    add_ref(16'h1234, 1'b0);
    add_ref(16'h00FF, 1'b0);
    add_ref(16'h5555, 1'b0);
    add_ref(16'hAAAA, 1'b1);
    wait_idle();

    // A slot count of zero behaves as a single slot.
    write_frames(4'd0);
    add_ref(16'h0007, 1'b0);
    add_ref(16'h0009, 1'b0);
    add_ref(16'h0007, 1'b1);
    wait_idle();

    // An oversized count behaves as all slots; then the count shrinks and grows mid-string,
    // leaving pages in the upper slots stored but out of the search.
    write_frames(4'd15);
    for (int i = 0; i < SLOTS; i++) add_ref(PAGE_PORT_W'(16'h0100 + i), 1'b0);
    wait_idle();
    write_frames(4'd2);
    add_ref(16'h0105, 1'b0);
    add_ref(16'h0101, 1'b0);
    wait_idle();
    write_frames(4'd8);
    add_ref(16'h0105, 1'b0);
    add_ref(16'h0100, 1'b1);
    wait_idle();

    // Random phases: mostly working-set strings, some noise and some strings left open.
    for (int p = 0; p < 12; p++) begin
      write_frames(CFG_W'(phase_frames[p]));
      gap_percent = phase_gaps[p % 4];
      queued = 0;
      while (queued < 45) begin
        if ($urandom_range(99) < 12) begin
          add_ref(PAGE_PORT_W'($urandom), $urandom_range(9) == 0);
          queued++;
        end else begin
          len = $urandom_range(4, 30);
          queue_string(len, $urandom_range(4) != 0);
          queued += len;
        end
      end
      wait_idle();
    end

    repeat (2 * SLOTS + 4) @(posedge clk);
    if (failed) begin
      $display("lfu_page_replacement_top: mismatch");
    end else begin
      $display("lfu_page_replacement_top: match");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("lfu_page_replacement_top: mismatch");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/lfu_pkg.sv
rtl/core/lfu_cell.sv
rtl/core/lfu_page_replacement_top.sv
bench/tb_lfu_page_replacement_top.sv
